FILE: hw/rtl/bayer_bilinear_demosaic_unit_macros.svh
// Assertion macros for the bilinear Bayer demosaic unit.
`ifndef BAYER_BILINEAR_DEMOSAIC_UNIT_MACROS_SVH
`define BAYER_BILINEAR_DEMOSAIC_UNIT_MACROS_SVH

`ifndef SYNTH
`define BBD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbd assertion failed");
`define BBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbd assertion failed");
`else
`define BBD_ASSERT_IMP(label, clk, rst, ante, cons)
`define BBD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/bbd_pkg.sv
// Shared constants for the bilinear Bayer demosaic unit.
`timescale 1ns / 1ps
package bbd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIX_BITS   = 8;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  localparam int REG_BITS   = 11;
  localparam int IDX_BITS   = 1;

  localparam logic [IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

endpackage

FILE: hw/rtl/bbd_if.sv
// Stream interfaces: raw Bayer samples in, RGB pixels out.
`timescale 1ns / 1ps
interface bbd_pix_if;
  logic                         valid;
  logic                         ready;
  logic [bbd_pkg::PIX_BITS-1:0] raw_pixel;
  logic                         is_padding;

  modport source (output valid, output raw_pixel, output is_padding, input ready);
  modport sink (input valid, input raw_pixel, input is_padding, output ready);
endinterface

interface bbd_rgb_if;
  logic                         valid;
  logic                         ready;
  logic [bbd_pkg::PIX_BITS-1:0] red;
  logic [bbd_pkg::PIX_BITS-1:0] green;
  logic [bbd_pkg::PIX_BITS-1:0] blue;
  logic                         frame_end;

  modport source (output valid, output red, output green, output blue,
                  output frame_end, input ready);
  modport sink (input valid, input red, input green, input blue,
                input frame_end, output ready);
endinterface

FILE: hw/rtl/bayer_bilinear_demosaic_unit.sv
// Bilinear Bayer demosaic over a raster stream, two line memories and a 3x3 window.
//
// pix_in takes one raw Bayer sample per word in raster order (green/blue on
// even rows, red/green on odd rows); rgb_out gives one RGB word per pixel.
// Results trail the input by image_width+1 words, so after each frame the
// host sends image_width+1 padding words to flush the last row.
// A word's result reaches rgb_out.valid in order: the line memory read and the
// window stage register at its accept edge, and the window/average stage loads
// the output register when that stage advances. One word is accepted per cycle
// unless rgb_out stalls; each line memory's single read and write port sets it.
// The user writes image_width / image_height on the cfg port only while the block
// is idle; the block does not enforce this. Reset clears the counters, window and
// output valid and sets both sizes to 1024; line memories are not cleared, rows
// above the image are masked. When rgb_out stalls, the output register holds
// its word; a window stage word to emit holds too, and drops pix_in.ready.
`timescale 1ns / 1ps
`include "bayer_bilinear_demosaic_unit_macros.svh"

module bayer_bilinear_demosaic_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bbd_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [bbd_pkg::REG_BITS-1:0]   cfg_data,
  bbd_pix_if.sink                        pix_in,
  bbd_rgb_if.source                      rgb_out
);

  typedef struct packed {
    logic [bbd_pkg::PIX_BITS-1:0] px;
    logic [bbd_pkg::COL_BITS-1:0] col;
    logic                         emit;
    logic                         last;
    logic                         top_z;
    logic                         bot_z;
    logic                         left_z;
    logic                         right_z;
    logic                         odd_row;
    logic                         odd_col;
  } s1_t;

  // configuration
  logic [bbd_pkg::REG_BITS-1:0] image_width;
  logic [bbd_pkg::REG_BITS-1:0] image_height;
  logic [bbd_pkg::REG_BITS-1:0] w_eff;
  logic [bbd_pkg::REG_BITS-1:0] h_eff;

  // counters
  logic [bbd_pkg::COL_BITS-1:0] in_col, in_col_next;
  logic [bbd_pkg::REG_BITS-1:0] in_row, in_row_next;
  logic [bbd_pkg::COL_BITS-1:0] out_col, out_col_next;
  logic [bbd_pkg::ROW_BITS-1:0] out_row, out_row_next;
  logic [bbd_pkg::REG_BITS-1:0] ic_p1, oc_p1, or_p1;
  logic                         emit_now, last_now, oc_wrap;

  // line memories
  logic [bbd_pkg::PIX_BITS-1:0] mem_up  [bbd_pkg::MAX_WIDTH];
  logic [bbd_pkg::PIX_BITS-1:0] mem_mid [bbd_pkg::MAX_WIDTH];
  logic [bbd_pkg::PIX_BITS-1:0] up_q, mid_q;

  // window stage
  s1_t                          s1, s1_next;
  logic                         s1_valid, s1_stall, s1_adv, s1_fwd;
  logic [bbd_pkg::PIX_BITS-1:0] fwd_up, fwd_mid, up_eff, mid_eff;
  logic [bbd_pkg::PIX_BITS-1:0] win [3][3];
  logic [bbd_pkg::PIX_BITS-1:0] nw  [3][3];
  logic [bbd_pkg::PIX_BITS-1:0] t00, t01, t02, t10, t12, t20, t21, t22, c2;
  logic [bbd_pkg::PIX_BITS+1:0] cross_sum, diag_sum;
  logic [bbd_pkg::PIX_BITS:0]   horiz_sum, vert_sum;
  logic [bbd_pkg::PIX_BITS-1:0] cross_avg, diag_avg, horiz_avg, vert_avg;
  logic [bbd_pkg::PIX_BITS-1:0] r_next, g_next, b_next;

  // output register
  logic                         out_valid;
  logic [bbd_pkg::PIX_BITS-1:0] out_r, out_g, out_b;
  logic                         out_last;

  logic acc;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bbd_pkg::REG_BITS'(bbd_pkg::MAX_WIDTH);
      image_height <= bbd_pkg::REG_BITS'(bbd_pkg::MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        bbd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        bbd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < bbd_pkg::REG_BITS'(2))
      w_eff = bbd_pkg::REG_BITS'(2);
    else if (image_width > bbd_pkg::REG_BITS'(bbd_pkg::MAX_WIDTH))
      w_eff = bbd_pkg::REG_BITS'(bbd_pkg::MAX_WIDTH);
    else
      w_eff = image_width;
    if (image_height < bbd_pkg::REG_BITS'(2))
      h_eff = bbd_pkg::REG_BITS'(2);
    else if (image_height > bbd_pkg::REG_BITS'(bbd_pkg::MAX_HEIGHT))
      h_eff = bbd_pkg::REG_BITS'(bbd_pkg::MAX_HEIGHT);
    else
      h_eff = image_height;
  end

  // ---------------- handshake ----------------
  assign s1_stall     = s1_valid && s1.emit && out_valid && !rgb_out.ready;
  assign s1_adv       = s1_valid && !s1_stall;
  assign pix_in.ready = !s1_stall;
  assign acc          = pix_in.valid && pix_in.ready;

  // ---------------- counters, evaluated at accept ----------------
  always_comb begin
    ic_p1    = {1'b0, in_col} + bbd_pkg::REG_BITS'(1);
    oc_p1    = {1'b0, out_col} + bbd_pkg::REG_BITS'(1);
    or_p1    = {1'b0, out_row} + bbd_pkg::REG_BITS'(1);
    emit_now = (in_row >= bbd_pkg::REG_BITS'(2)) ||
               (in_row == bbd_pkg::REG_BITS'(1) && in_col != '0);
    oc_wrap  = oc_p1 >= w_eff;
    last_now = (or_p1 >= h_eff) && oc_wrap;

    if (ic_p1 >= w_eff) begin
      in_col_next = '0;
      in_row_next = in_row + bbd_pkg::REG_BITS'(1);
    end else begin
      in_col_next = ic_p1[bbd_pkg::COL_BITS-1:0];
      in_row_next = in_row;
    end
    out_col_next = out_col;
    out_row_next = out_row;
    if (emit_now) begin
      if (last_now) begin
        in_col_next  = '0;
        in_row_next  = '0;
        out_col_next = '0;
        out_row_next = '0;
      end else if (oc_wrap) begin
        out_col_next = '0;
        out_row_next = or_p1[bbd_pkg::ROW_BITS-1:0];
      end else begin
        out_col_next = oc_p1[bbd_pkg::COL_BITS-1:0];
      end
    end

    s1_next.px      = pix_in.is_padding ? '0 : pix_in.raw_pixel;
    s1_next.col     = in_col;
    s1_next.emit    = emit_now;
    s1_next.last    = last_now;
    s1_next.top_z   = out_row == '0;
    s1_next.bot_z   = or_p1 >= h_eff;
    s1_next.left_z  = out_col == '0;
    s1_next.right_z = oc_wrap;
    s1_next.odd_row = out_row[0];
    s1_next.odd_col = out_col[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (acc) begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // ---------------- line memories ----------------
  always_ff @(posedge clk) begin
    if (acc)
      up_q <= mem_up[in_col];
    if (s1_adv)
      mem_up[s1.col] <= mid_eff;
  end

  always_ff @(posedge clk) begin
    if (acc)
      mid_q <= mem_mid[in_col];
    if (s1_adv)
      mem_mid[s1.col] <= s1.px;
  end

  // ---------------- window stage ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
      // previous word writes the same column on this edge: the read saw stale data
      s1_fwd   <= s1_valid && (s1.col == in_col);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1      <= s1_next;
      fwd_up  <= mid_eff;
      fwd_mid <= s1.px;
    end
  end

  assign up_eff  = s1_fwd ? fwd_up  : up_q;
  assign mid_eff = s1_fwd ? fwd_mid : mid_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nw[r][0] = win[r][1];
      nw[r][1] = win[r][2];
    end
    nw[0][2] = up_eff;
    nw[1][2] = mid_eff;
    nw[2][2] = s1.px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          win[r][c] <= '0;
    end else if (s1_adv) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          win[r][c] <= nw[r][c];
    end
  end

  // taps outside the image read as zero
  always_comb begin
    t00 = (s1.top_z || s1.left_z)  ? '0 : nw[0][0];
    t01 = s1.top_z                 ? '0 : nw[0][1];
    t02 = (s1.top_z || s1.right_z) ? '0 : nw[0][2];
    t10 = s1.left_z                ? '0 : nw[1][0];
    t12 = s1.right_z               ? '0 : nw[1][2];
    t20 = (s1.bot_z || s1.left_z)  ? '0 : nw[2][0];
    t21 = s1.bot_z                 ? '0 : nw[2][1];
    t22 = (s1.bot_z || s1.right_z) ? '0 : nw[2][2];
    c2  = nw[1][1];

    cross_sum = {2'b00, t01} + {2'b00, t21} + {2'b00, t10} + {2'b00, t12};
    diag_sum  = {2'b00, t00} + {2'b00, t02} + {2'b00, t20} + {2'b00, t22};
    horiz_sum = {1'b0, t10} + {1'b0, t12};
    vert_sum  = {1'b0, t01} + {1'b0, t21};
    cross_avg = cross_sum[bbd_pkg::PIX_BITS+1:2];
    diag_avg  = diag_sum[bbd_pkg::PIX_BITS+1:2];
    horiz_avg = horiz_sum[bbd_pkg::PIX_BITS:1];
    vert_avg  = vert_sum[bbd_pkg::PIX_BITS:1];

    case ({s1.odd_row, s1.odd_col})
      2'b00: begin   // green on a blue row
        r_next = vert_avg;  g_next = c2;        b_next = horiz_avg;
      end
      2'b01: begin   // blue
        r_next = diag_avg;  g_next = cross_avg; b_next = c2;
      end
      2'b10: begin   // red
        r_next = c2;        g_next = cross_avg; b_next = diag_avg;
      end
      default: begin // green on a red row
        r_next = horiz_avg; g_next = c2;        b_next = vert_avg;
      end
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (s1_adv && s1.emit)
      out_valid <= 1'b1;
    else if (rgb_out.ready)
      out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.emit) begin
      out_r    <= r_next;
      out_g    <= g_next;
      out_b    <= b_next;
      out_last <= s1.last;
    end
  end

  assign rgb_out.valid     = out_valid;
  assign rgb_out.red       = out_r;
  assign rgb_out.green     = out_g;
  assign rgb_out.blue      = out_b;
  assign rgb_out.frame_end = out_last;

  // ---------------- assertions ----------------
  `BBD_ASSERT_IMP(a_fwd_needs_stage, clk, rst, s1_fwd, s1_valid)
  `BBD_ASSERT_NEXT(a_frame_end_resets, clk, rst, acc && emit_now && last_now,
                   in_col == '0 && in_row == '0 && out_col == '0 && out_row == '0)
  `BBD_ASSERT_NEXT(a_no_emit_no_word, clk, rst,
                   s1_valid && !s1.emit && (!out_valid || rgb_out.ready), !out_valid)

endmodule
